// ===== src/sta_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sta_pkg
// Shared types, constants and helper functions of the sonar target tracker.
// ----------------------------------------------------------------------------
package sta_pkg;

    // Sizes
    localparam int CORDIC_STEPS = 16;
    localparam int SENSOR_COUNT = 4;
    localparam int STEP_W       = 5;
    localparam int QUEUE_DEPTH  = 2;
    localparam int DIV_BITS     = 48;
    localparam int DIV_CNT_W    = 6;
    localparam int DEN_W        = 17;

    // Fixed-point constants
    localparam logic [16:0] TRUST_ONE    = 17'd65536;
    localparam logic [16:0] TRUST_LOW    = 17'd6553;
    localparam logic signed [33:0] CORDIC_KX = 34'sd652032874;
    localparam logic [31:0] VEL_DT_MIN   = 32'd10;
    localparam logic [31:0] VEL_DT_MAX   = 32'd1000;
    localparam logic [10:0] MS_SCALE_X2  = 11'd2000;

    // Operation codes of the input item
    localparam logic [1:0] OP_SONAR  = 2'd0;
    localparam logic [1:0] OP_POINT  = 2'd1;
    localparam logic [1:0] OP_DECAY  = 2'd2;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    // Register indexes on the configuration port
    localparam logic [1:0] REG_GAIN    = 2'd0;
    localparam logic [1:0] REG_TIMEOUT = 2'd1;
    localparam logic [1:0] REG_MINR    = 2'd2;
    localparam logic [1:0] REG_MAXR    = 2'd3;

    typedef enum logic [1:0] {
        CMD_SONAR,
        CMD_POINT,
        CMD_DECAY,
        CMD_NONE
    } cmd_kind_t;

    // Classified request handed from the front to the back
    typedef struct packed {
        cmd_kind_t          kind;
        logic [1:0]         quad;
        logic signed [15:0] resid;
        logic [17:0]        sonar_dist;
        logic signed [23:0] base_x;
        logic signed [23:0] base_y;
        logic [31:0]        now;
    } cmd_t;

    typedef struct packed {
        logic [16:0] gain;
        logic [15:0] timeout;
        logic [17:0] min_range;
        logic [17:0] max_range;
    } cfg_t;

    typedef enum logic [3:0] {
        BK_IDLE,
        BK_CORDIC,
        BK_PROJ_X,
        BK_PROJ_Y,
        BK_PROJ_END,
        BK_TAKE,
        BK_SM_X,
        BK_SM_Y,
        BK_SM_END,
        BK_VX,
        BK_VX_WAIT,
        BK_VY,
        BK_VY_WAIT,
        BK_COMMIT,
        BK_DECAY,
        BK_OUT
    } bk_state_t;

    // Arctangent of 2^-i in units of 2^32 per turn
    function automatic logic [29:0] atan_turn(input logic [STEP_W-1:0] idx);
        logic [29:0] v;
        unique case (idx)
            5'd0:  v = 30'h20000000;
            5'd1:  v = 30'h12E4051E;
            5'd2:  v = 30'h09FB385B;
            5'd3:  v = 30'h051111D4;
            5'd4:  v = 30'h028B0D43;
            5'd5:  v = 30'h0145D7E1;
            5'd6:  v = 30'h00A2F61E;
            5'd7:  v = 30'h00517C55;
            5'd8:  v = 30'h0028BE53;
            5'd9:  v = 30'h00145F2F;
            5'd10: v = 30'h000A2F98;
            5'd11: v = 30'h000517CC;
            5'd12: v = 30'h00028BE6;
            5'd13: v = 30'h000145F3;
            5'd14: v = 30'h0000A2FA;
            5'd15: v = 30'h0000517D;
            5'd16: v = 30'h000028BE;
            5'd17: v = 30'h0000145F;
            5'd18: v = 30'h00000A30;
            5'd19: v = 30'h00000518;
            5'd20: v = 30'h0000028C;
            5'd21: v = 30'h00000146;
            5'd22: v = 30'h000000A3;
            5'd23: v = 30'h00000051;
            default: v = 30'h0;
        endcase
        return v;
    endfunction

    // Clamp to the signed 24-bit range
    function automatic logic signed [23:0] sat24(input logic signed [63:0] v);
        logic signed [23:0] r;
        if (v > 64'sd8388607)
            r = 24'sh7FFFFF;
        else if (v < -64'sd8388608)
            r = 24'sh800000;
        else
            r = v[23:0];
        return r;
    endfunction

endpackage
`default_nettype wire

// ===== src/sta_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sta_queue
// Short request queue between the classifying front and the working back.
// ----------------------------------------------------------------------------
module sta_queue (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  wire sta_pkg::cmd_t push_data,
    output logic               full,
    input  wire logic          pop,
    output logic               not_empty,
    output sta_pkg::cmd_t      pop_data
);
    import sta_pkg::*;

    cmd_t       mem [QUEUE_DEPTH];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;

    assign full      = (count_reg == 2'(QUEUE_DEPTH));
    assign not_empty = (count_reg != 2'd0);
    assign pop_data  = mem[rd_ptr_reg];

    // Store pushed request
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    // Advance pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= ~rd_ptr_reg;
            if (push && !pop)
                count_reg <= count_reg + 2'd1;
            else if (pop && !push)
                count_reg <= count_reg - 2'd1;
        end
    end

endmodule
`default_nettype wire

// ===== src/sta_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sta_front
// Accepts input items, rejects bad sonar reports and reduces the bearing to
// a quadrant and a residual angle for the back.
// ----------------------------------------------------------------------------
module sta_front (
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic [1:0]         operation,
    input  wire logic signed [23:0] robot_x,
    input  wire logic signed [23:0] robot_y,
    input  wire logic [15:0]        robot_heading,
    input  wire logic [2:0]         sensor_index,
    input  wire logic [17:0]        distance,
    input  wire logic signed [23:0] meas_x,
    input  wire logic signed [23:0] meas_y,
    input  wire logic [31:0]        now_ms,
    input  wire sta_pkg::cfg_t      cfg,
    input  wire logic               q_full,
    output logic                    push,
    output sta_pkg::cmd_t           push_data
);
    import sta_pkg::*;

    logic        sonar_ok;
    logic [15:0] bearing;
    logic [15:0] shifted;
    logic [1:0]  quad;

    assign in_ready = !q_full;
    assign push     = in_valid && !q_full;

    // Validate the report
    assign sonar_ok = ({1'b0, sensor_index} < 4'(SENSOR_COUNT))
                   && (distance >= cfg.min_range) && (distance <= cfg.max_range);

    // Reduce bearing to quadrant and residual
    assign bearing = robot_heading + {sensor_index[1:0], 14'd0};
    assign shifted = bearing + 16'd8192;
    assign quad    = shifted[15:14];

    always_comb
    begin
        push_data.quad       = quad;
        push_data.resid      = $signed({bearing[15:14] - quad, bearing[13:0]});
        push_data.sonar_dist = distance;
        push_data.now        = now_ms;
        push_data.base_x     = robot_x;
        push_data.base_y     = robot_y;
        priority if (operation == OP_SONAR)
            push_data.kind = sonar_ok ? CMD_SONAR : CMD_NONE;
        else if (operation == OP_POINT)
        begin
            push_data.kind   = CMD_POINT;
            push_data.base_x = meas_x;
            push_data.base_y = meas_y;
        end
        else if (operation == OP_DECAY)
            push_data.kind = CMD_DECAY;
        else
            push_data.kind = CMD_NONE;
    end

endmodule
`default_nettype wire

// ===== src/sta_div.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sta_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module sta_div (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    input  wire logic [47:0]         num,
    input  wire logic [16:0]         den,
    output logic                     done,
    output logic [47:0]              quo
);
    import sta_pkg::*;

    logic [DIV_BITS-1:0]  quo_reg;
    logic [DEN_W:0]       rem_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;
    logic [DEN_W:0]       rem_sh;
    logic                 fits;

    assign rem_sh = {rem_reg[DEN_W-1:0], quo_reg[DIV_BITS-1]};
    assign fits   = (rem_sh >= {1'b0, den});
    assign quo    = quo_reg;
    assign done   = done_reg;

    // Load operands, then run one restoring step per quotient bit while busy
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= num;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[DIV_BITS-2:0], fits};
            rem_reg <= fits ? (rem_sh - {1'b0, den}) : rem_sh;
        end
    end

    // Count steps
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                cnt_reg  <= DIV_CNT_W'(DIV_BITS);
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == DIV_CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

endmodule
`default_nettype wire

// ===== src/sta_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sta_back
// Executes queued requests: CORDIC bearing, projection, alpha smoothing,
// velocity and confidence decay, and holds the result register.
// ----------------------------------------------------------------------------
module sta_back (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire sta_pkg::cfg_t cfg,
    input  wire logic          q_not_empty,
    input  wire sta_pkg::cmd_t q_data,
    output logic               pop,
    output logic               out_valid,
    input  wire logic          out_ready,
    output logic signed [23:0] track_x,
    output logic signed [23:0] track_y,
    output logic signed [23:0] speed_x,
    output logic signed [23:0] speed_y,
    output logic [16:0]        confidence,
    output logic               accepted
);
    import sta_pkg::*;

    bk_state_t state_reg, state_next;

    cmd_t                cmd_reg;
    logic signed [33:0]  cx_reg, cy_reg;
    logic signed [32:0]  cz_reg;
    logic [STEP_W-1:0]   step_reg;
    logic signed [52:0]  prod_reg;
    logic signed [23:0]  mx_reg, my_reg, nx_reg, ny_reg;
    logic signed [23:0]  est_x_reg, est_y_reg, vel_x_reg, vel_y_reg;
    logic [16:0]         trust_reg;
    logic [31:0]         seen_reg;
    logic                acc_reg;
    logic                neg_reg;
    logic                out_valid_reg;

    logic signed [33:0]  shx, shy, cos_v, sin_v, mul_b;
    logic signed [32:0]  atan_v;
    logic signed [18:0]  mul_a;
    logic signed [52:0]  mul_p;
    logic [16:0]         gain_eff;
    logic [31:0]         dt;
    logic                vel_win;
    logic signed [24:0]  dx, dy, delta;
    logic [24:0]         mag;
    logic [47:0]         div_num;
    logic [16:0]         div_den;
    logic [16:0]         tmo_den;
    logic                div_start, div_done;
    logic [47:0]         div_quo;
    logic signed [23:0]  vel_q;
    logic signed [52:0]  proj_rnd, sm_rnd;
    logic signed [23:0]  proj_v, sm_v;
    logic signed [23:0]  proj_base, sm_est;
    logic                out_load;

    // CORDIC micro-rotation terms
    assign shx    = cx_reg >>> step_reg;
    assign shy    = cy_reg >>> step_reg;
    assign atan_v = $signed({3'b000, atan_turn(step_reg)});

    // Map rotated vector back to its quadrant
    always_comb
    begin
        unique case (cmd_reg.quad)
            2'd0:    begin cos_v = cx_reg;  sin_v = cy_reg;  end
            2'd1:    begin cos_v = -cy_reg; sin_v = cx_reg;  end
            2'd2:    begin cos_v = -cx_reg; sin_v = -cy_reg; end
            default: begin cos_v = cy_reg;  sin_v = -cx_reg; end
        endcase
    end

    assign gain_eff = (cfg.gain > TRUST_ONE) ? TRUST_ONE : cfg.gain;
    assign dx       = 25'(mx_reg) - 25'(est_x_reg);
    assign dy       = 25'(my_reg) - 25'(est_y_reg);
    assign dt       = cmd_reg.now - seen_reg;
    assign vel_win  = (dt > VEL_DT_MIN) && (dt < VEL_DT_MAX);

    // Shared multiplier
    always_comb
    begin
        unique case (state_reg)
            BK_PROJ_X:
            begin
                mul_a = $signed({1'b0, cmd_reg.sonar_dist});
                mul_b = cos_v;
            end
            BK_PROJ_Y:
            begin
                mul_a = $signed({1'b0, cmd_reg.sonar_dist});
                mul_b = sin_v;
            end
            BK_SM_X:   begin mul_a = $signed({2'b00, gain_eff}); mul_b = 34'(dx); end
            default:   begin mul_a = $signed({2'b00, gain_eff}); mul_b = 34'(dy); end
        endcase
    end
    assign mul_p = 53'(mul_a) * 53'(mul_b);

    // Round projection to Q8.16 and add own position
    assign proj_base = (state_reg == BK_PROJ_Y) ? cmd_reg.base_x : cmd_reg.base_y;
    assign proj_rnd  = prod_reg + 53'sd536870912;
    assign proj_v    = sat24(64'(proj_base) + 64'($signed(proj_rnd[52:30])));

    // Smoothing step
    assign sm_est = (state_reg == BK_SM_Y) ? est_x_reg : est_y_reg;
    assign sm_rnd = prod_reg + 53'sd32768;
    assign sm_v   = sat24(64'(sm_est) + 64'($signed(sm_rnd[52:16])));

    // Velocity divider operands
    assign delta = (state_reg == BK_VX) ? (25'(nx_reg) - 25'(est_x_reg))
                                        : (25'(ny_reg) - 25'(est_y_reg));
    assign mag   = delta[24] ? 25'(-delta) : 25'(delta);

    assign tmo_den = (cfg.timeout == 16'd0) ? 17'd1 : {1'b0, cfg.timeout};

    // Start the divider: velocity in its own states, decay when the tick is popped
    always_comb
    begin
        div_start = 1'b0;
        div_num   = 48'(mag) * 48'(MS_SCALE_X2) + 48'(dt);
        div_den   = {dt[15:0], 1'b0};
        unique case (state_reg)
            BK_VX, BK_VY: div_start = 1'b1;
            BK_IDLE:
            begin
                div_start = q_not_empty && (q_data.kind == CMD_DECAY);
                div_num   = {q_data.now - seen_reg, 16'd0};
                div_den   = tmo_den;
            end
            BK_DECAY: div_den = tmo_den;
            default: div_start = 1'b0;
        endcase
    end

    // Signed, saturated velocity from quotient
    always_comb
    begin
        if (neg_reg)
            vel_q = (div_quo > 48'd8388608) ? 24'sh800000 : 24'(-$signed(div_quo[24:0]));
        else
            vel_q = (div_quo > 48'd8388607) ? 24'sh7FFFFF : $signed(div_quo[23:0]);
    end

    sta_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quo   (div_quo)
    );

    assign out_load = (state_reg == BK_OUT) && (!out_valid_reg || out_ready);
    assign pop      = (state_reg == BK_IDLE) && q_not_empty;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BK_IDLE:
                if (q_not_empty)
                begin
                    unique case (q_data.kind)
                        CMD_SONAR: state_next = BK_CORDIC;
                        CMD_POINT: state_next = BK_TAKE;
                        CMD_DECAY: state_next = BK_DECAY;
                        default:   state_next = BK_OUT;
                    endcase
                end
            BK_CORDIC:
                if (step_reg == STEP_W'(CORDIC_STEPS - 1))
                    state_next = BK_PROJ_X;
            BK_PROJ_X:   state_next = BK_PROJ_Y;
            BK_PROJ_Y:   state_next = BK_PROJ_END;
            BK_PROJ_END: state_next = BK_TAKE;
            BK_TAKE:     state_next = (trust_reg > TRUST_LOW) ? BK_SM_X : BK_OUT;
            BK_SM_X:     state_next = BK_SM_Y;
            BK_SM_Y:     state_next = BK_SM_END;
            BK_SM_END:   state_next = vel_win ? BK_VX : BK_COMMIT;
            BK_VX:       state_next = BK_VX_WAIT;
            BK_VX_WAIT:  if (div_done) state_next = BK_VY;
            BK_VY:       state_next = BK_VY_WAIT;
            BK_VY_WAIT:  if (div_done) state_next = BK_COMMIT;
            BK_COMMIT:   state_next = BK_OUT;
            BK_DECAY:    state_next = BK_DECAY;
            BK_OUT:      if (out_load) state_next = BK_IDLE;
            default:     state_next = BK_IDLE;
        endcase
        // Decay waits on the divider in its own state
        if (state_reg == BK_DECAY && div_done)
            state_next = BK_OUT;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= BK_IDLE;
        else
            state_reg <= state_next;
    end

    // Working datapath
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            BK_IDLE:
                if (q_not_empty)
                begin
                    cmd_reg  <= q_data;
                    cx_reg   <= CORDIC_KX;
                    cy_reg   <= '0;
                    cz_reg   <= {q_data.resid[15], q_data.resid, 16'd0};
                    step_reg <= '0;
                    mx_reg   <= q_data.base_x;
                    my_reg   <= q_data.base_y;
                end
            BK_CORDIC:
            begin
                if (!cz_reg[32])
                begin
                    cx_reg <= cx_reg - shy;
                    cy_reg <= cy_reg + shx;
                    cz_reg <= cz_reg - atan_v;
                end
                else
                begin
                    cx_reg <= cx_reg + shy;
                    cy_reg <= cy_reg - shx;
                    cz_reg <= cz_reg + atan_v;
                end
                step_reg <= step_reg + 1'b1;
            end
            BK_PROJ_X: prod_reg <= mul_p;
            BK_PROJ_Y:
            begin
                mx_reg   <= proj_v;
                prod_reg <= mul_p;
            end
            BK_PROJ_END: my_reg <= proj_v;
            BK_SM_X:     prod_reg <= mul_p;
            BK_SM_Y:
            begin
                nx_reg   <= sm_v;
                prod_reg <= mul_p;
            end
            BK_SM_END: ny_reg <= sm_v;
            BK_VX:     neg_reg <= delta[24];
            BK_VY:     neg_reg <= delta[24];
            default:   ;
        endcase
    end

    // Track state and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            est_x_reg     <= '0;
            est_y_reg     <= '0;
            vel_x_reg     <= '0;
            vel_y_reg     <= '0;
            trust_reg     <= '0;
            seen_reg      <= '0;
            acc_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
            track_x       <= '0;
            track_y       <= '0;
            speed_x       <= '0;
            speed_y       <= '0;
            confidence    <= '0;
            accepted      <= 1'b0;
        end
        else
        begin
            if (pop)
                acc_reg <= 1'b0;
            if (state_reg == BK_TAKE && trust_reg <= TRUST_LOW)
            begin
                est_x_reg <= mx_reg;
                est_y_reg <= my_reg;
                vel_x_reg <= '0;
                vel_y_reg <= '0;
                trust_reg <= TRUST_ONE;
                seen_reg  <= cmd_reg.now;
                acc_reg   <= 1'b1;
            end
            if (state_reg == BK_VX_WAIT && div_done)
                vel_x_reg <= vel_q;
            if (state_reg == BK_VY_WAIT && div_done)
                vel_y_reg <= vel_q;
            if (state_reg == BK_COMMIT)
            begin
                est_x_reg <= nx_reg;
                est_y_reg <= ny_reg;
                trust_reg <= TRUST_ONE;
                seen_reg  <= cmd_reg.now;
                acc_reg   <= 1'b1;
            end
            if (state_reg == BK_DECAY && div_done)
                trust_reg <= (div_quo >= 48'(TRUST_ONE)) ? 17'd0
                                                         : TRUST_ONE - div_quo[16:0];
            // Present the result, drop it once taken
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
                track_x       <= est_x_reg;
                track_y       <= est_y_reg;
                speed_x       <= vel_x_reg;
                speed_y       <= vel_y_reg;
                confidence    <= trust_reg;
                accepted      <= acc_reg;
            end
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    assign out_valid = out_valid_reg;

endmodule
`default_nettype wire

// ===== src/sonar_target_alpha_tracker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sonar_target_alpha_tracker
// Single-target alpha-filter tracker fed by sonar ranges or direct points.
// ----------------------------------------------------------------------------
// One result per input item. A front stage classifies each request and
// queues up to two; the back stage works on one at a time. A rejected report
// or an unused operation goes straight to the result; a direct point either
// resets the track or is smoothed; a sonar report first runs the CORDIC
// rotation and the projection. A smoothed point that falls in the velocity
// window recomputes the velocity with two divisions, and a decay tick uses
// one. The 48-step bit-serial divider serves both.
// Configuration goes through the APB port, registers at byte addresses 0,
// 4, 8 and 12.
// ----------------------------------------------------------------------------
module sonar_target_alpha_tracker (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [3:0]         paddr,
    input  wire logic [31:0]        pwdata,
    output logic [31:0]             prdata,
    output logic                    pready,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic [1:0]         operation,
    input  wire logic signed [23:0] robot_x,
    input  wire logic signed [23:0] robot_y,
    input  wire logic [15:0]        robot_heading,
    input  wire logic [2:0]         sensor_index,
    input  wire logic [17:0]        distance,
    input  wire logic signed [23:0] meas_x,
    input  wire logic signed [23:0] meas_y,
    input  wire logic [31:0]        now_ms,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic signed [23:0]      track_x,
    output logic signed [23:0]      track_y,
    output logic signed [23:0]      speed_x,
    output logic signed [23:0]      speed_y,
    output logic [16:0]             confidence,
    output logic                    accepted
);
    import sta_pkg::*;

    cfg_t cfg_reg;
    logic cfg_wr;
    logic q_full, q_push, q_pop, q_not_empty;
    cmd_t q_in, q_out;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.gain      <= 17'd32768;
            cfg_reg.timeout   <= 16'd500;
            cfg_reg.min_range <= 18'd1966;
            cfg_reg.max_range <= 18'd163840;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[3:2])
                REG_GAIN:    cfg_reg.gain      <= pwdata[16:0];
                REG_TIMEOUT: cfg_reg.timeout   <= pwdata[15:0];
                REG_MINR:    cfg_reg.min_range <= pwdata[17:0];
                default:     cfg_reg.max_range <= pwdata[17:0];
            endcase
        end
    end

    // Read back
    always_comb
    begin
        unique case (paddr[3:2])
            REG_GAIN:    prdata = 32'(cfg_reg.gain);
            REG_TIMEOUT: prdata = 32'(cfg_reg.timeout);
            REG_MINR:    prdata = 32'(cfg_reg.min_range);
            default:     prdata = 32'(cfg_reg.max_range);
        endcase
    end

    sta_front u_front (
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .operation     (operation),
        .robot_x       (robot_x),
        .robot_y       (robot_y),
        .robot_heading (robot_heading),
        .sensor_index  (sensor_index),
        .distance      (distance),
        .meas_x        (meas_x),
        .meas_y        (meas_y),
        .now_ms        (now_ms),
        .cfg           (cfg_reg),
        .q_full        (q_full),
        .push          (q_push),
        .push_data     (q_in)
    );

    sta_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .pop_data  (q_out)
    );

    sta_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .q_not_empty (q_not_empty),
        .q_data      (q_out),
        .pop         (q_pop),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .track_x     (track_x),
        .track_y     (track_y),
        .speed_x     (speed_x),
        .speed_y     (speed_y),
        .confidence  (confidence),
        .accepted    (accepted)
    );

endmodule
`default_nettype wire

// ===== src/sta_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sta_checker
// Port-level checks of the tracker, bound to the top level.
// ----------------------------------------------------------------------------
module sta_checker (
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               pready,
    input wire logic               out_valid,
    input wire logic               out_ready,
    input wire logic signed [23:0] track_x,
    input wire logic [16:0]        confidence,
    input wire logic               accepted
);
    import sta_pkg::*;

    // Hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(track_x) && $stable(confidence))
        else $error("result changed while stalled");

    a_pready: assert property (@(posedge clk) disable iff (!rst_n) pready)
        else $error("pready dropped");

    // An update always restores full confidence
    a_acc_full: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && accepted |-> confidence == TRUST_ONE)
        else $error("accepted update without full confidence");

    a_conf_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> confidence <= TRUST_ONE)
        else $error("confidence above one");

endmodule

bind sonar_target_alpha_tracker sta_checker u_sta_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .pready     (pready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .track_x    (track_x),
    .confidence (confidence),
    .accepted   (accepted)
);
`default_nettype wire
